// File: rtl/calendar_field_editor_defines.svh
// assertion macros shared by the calendar field editor rtl
`ifndef CALENDAR_FIELD_EDITOR_DEFINES_SVH
`define CALENDAR_FIELD_EDITOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cfe_pkg.sv
// types, constants and month length function for the calendar field editor
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

    localparam int REQ_W    = 4;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd2000;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2099;

    // multiplicative inverse of 25 modulo 4096, and largest multiple quotient
    localparam logic [YEAR_W-1:0] INV25       = 12'd3113;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 12'd163;

    typedef enum logic [REQ_W-1:0] {
        REQ_DAY_UP     = 4'd0,
        REQ_DAY_DOWN   = 4'd1,
        REQ_MONTH_UP   = 4'd2,
        REQ_MONTH_DOWN = 4'd3,
        REQ_YEAR_UP    = 4'd4,
        REQ_YEAR_DOWN  = 4'd5,
        REQ_HOUR_UP    = 4'd6,
        REQ_HOUR_DOWN  = 4'd7,
        REQ_MIN_UP     = 4'd8,
        REQ_MIN_DOWN   = 4'd9
    } req_t;

    // days in a month; months outside 1..12 count as 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/calendar_field_editor.sv
// calendar field editor: one date/time edit per item, input and result registered
//
// usage
//   an item (req_type and the cur_* fields) is taken at a rising edge with start
//   high and busy low. busy is held low: the block takes an item every cycle.
//   the item is captured in an input register, edited by one pass of
//   combinational logic and captured in a result register.
//   the result is loaded at the next edge, shows on the new_* ports with done high
//   for one cycle and is taken by the receiver in that cycle (throughput 1 item
//   per cycle). the receiver cannot stall; each result shows once.
//   the slowest path is the divisible-by-25 test of the leap year rule, a
//   12 by 12 bit constant multiply feeding a compare and the day clamp.
//   day edits wrap within the month, month edits wrap within the year and
//   clamp the day, year edits step by one inside 2000..2099 and clamp the
//   day, hour edits wrap at 24, minute edits wrap at 60 and clear seconds.
//   unknown request codes pass every field through.
//   reset clears the valid flags only, so no result appears after reset until
//   a new item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_field_editor_defines.svh"

module calendar_field_editor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    input  wire logic [cfe_pkg::REQ_W-1:0]     req_type,
    input  wire logic [cfe_pkg::YEAR_W-1:0]    cur_year,
    input  wire logic [cfe_pkg::MONTH_W-1:0]   cur_month,
    input  wire logic [cfe_pkg::DAY_W-1:0]     cur_day,
    input  wire logic [cfe_pkg::HOUR_W-1:0]    cur_hour,
    input  wire logic [cfe_pkg::MINUTE_W-1:0]  cur_minute,
    input  wire logic [cfe_pkg::SECOND_W-1:0]  cur_second,
    output logic [cfe_pkg::YEAR_W-1:0]         new_year,
    output logic [cfe_pkg::MONTH_W-1:0]        new_month,
    output logic [cfe_pkg::DAY_W-1:0]          new_day,
    output logic [cfe_pkg::HOUR_W-1:0]         new_hour,
    output logic [cfe_pkg::MINUTE_W-1:0]       new_minute,
    output logic [cfe_pkg::SECOND_W-1:0]       new_second
);

    import cfe_pkg::*;

    logic                in_valid_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;

    logic                done_reg;
    logic [YEAR_W-1:0]   year_out_reg;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [DAY_W-1:0]    day_out_reg;
    logic [HOUR_W-1:0]   hour_out_reg;
    logic [MINUTE_W-1:0] minute_out_reg;
    logic [SECOND_W-1:0] second_out_reg;

    logic [YEAR_W-1:0]   year_next;
    logic [MONTH_W-1:0]  month_next;
    logic [DAY_W-1:0]    day_next;
    logic [HOUR_W-1:0]   hour_next;
    logic [MINUTE_W-1:0] minute_next;
    logic [SECOND_W-1:0] second_next;

    logic                accept;
    logic [YEAR_W-1:0]   prod25;
    logic                div4;
    logic                div16;
    logic                div25;
    logic                leap_cur;
    logic [DAY_W-1:0]    len_cur;
    logic [DAY_W:0]      day_inc;
    logic [MONTH_W-1:0]  month_up;
    logic [MONTH_W:0]    month_sum;
    logic [MONTH_W-1:0]  month_down;
    logic [YEAR_W:0]     year_inc;
    logic [YEAR_W-1:0]   year_dec;
    logic [YEAR_W-1:0]   year_up;
    logic [YEAR_W-1:0]   year_down;
    logic [HOUR_W:0]     hour_inc;
    logic [HOUR_W:0]     hour_dec;
    logic [MINUTE_W:0]   min_inc;
    logic [MINUTE_W:0]   min_dec;
    logic [MONTH_W-1:0]  clamp_month;
    logic                clamp_leap;
    logic [DAY_W-1:0]    clamp_len;
    logic [DAY_W-1:0]    day_clamped;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            year_reg   <= cur_year;
            month_reg  <= cur_month;
            day_reg    <= cur_day;
            hour_reg   <= cur_hour;
            minute_reg <= cur_minute;
            second_reg <= cur_second;
        end
    end

    // leap test on the current year: divisible by 25 via modular inverse
    assign prod25   = year_reg * INV25;
    assign div4     = (year_reg[1:0] == 2'd0);
    assign div16    = (year_reg[3:0] == 4'd0);
    assign div25    = (prod25 <= DIV25_LIMIT);
    assign leap_cur = div4 && (!div25 || div16);
    assign len_cur  = month_len(month_reg, leap_cur);
    assign day_inc  = {1'b0, day_reg} + 6'd1;

    // month steps, wrap within 1..12 for any 4-bit month
    assign month_up  = (month_reg >= 4'd12) ? (month_reg - 4'd11) : (month_reg + 4'd1);
    assign month_sum = {1'b0, month_reg} + 5'd10;
    always_comb
    begin
        if (month_sum >= 5'd24)
        begin
            month_down = month_sum[MONTH_W-1:0] - 4'd7;
        end
        else if (month_sum >= 5'd12)
        begin
            month_down = month_sum[MONTH_W-1:0] - 4'd11;
        end
        else
        begin
            month_down = month_sum[MONTH_W-1:0] + 4'd1;
        end
    end

    // year steps, saturated into the supported range
    assign year_inc = {1'b0, year_reg} + 13'd1;
    assign year_dec = (year_reg == '0) ? '0 : (year_reg - 12'd1);
    assign year_up  = (year_inc < {1'b0, YEAR_MIN}) ? YEAR_MIN :
                      (year_inc > {1'b0, YEAR_MAX}) ? YEAR_MAX : year_inc[YEAR_W-1:0];
    assign year_down = (year_dec < YEAR_MIN) ? YEAR_MIN :
                       (year_dec > YEAR_MAX) ? YEAR_MAX : year_dec;

    // hour and minute wraps
    assign hour_inc = {1'b0, hour_reg} + 6'd1;
    assign hour_dec = {1'b0, hour_reg} + 6'd23;
    assign min_inc  = {1'b0, minute_reg} + 7'd1;
    assign min_dec  = {1'b0, minute_reg} + 7'd59;

    // day clamp after month or year edits; saturated years are leap when divisible by 4
    always_comb
    begin
        clamp_month = month_reg;
        clamp_leap  = leap_cur;
        case (req_t'(req_reg))
            REQ_MONTH_UP:   clamp_month = month_up;
            REQ_MONTH_DOWN: clamp_month = month_down;
            REQ_YEAR_UP:    clamp_leap  = (year_up[1:0] == 2'd0);
            REQ_YEAR_DOWN:  clamp_leap  = (year_down[1:0] == 2'd0);
            default:        clamp_leap  = leap_cur;
        endcase
    end

    assign clamp_len   = month_len(clamp_month, clamp_leap);
    assign day_clamped = (day_reg > clamp_len) ? clamp_len : day_reg;

    // field select per request
    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        case (req_t'(req_reg))
            REQ_DAY_UP:
            begin
                day_next = (day_inc > {1'b0, len_cur}) ? 5'd1 : day_inc[DAY_W-1:0];
            end
            REQ_DAY_DOWN:
            begin
                if (day_reg <= 5'd1 || (day_reg - 5'd1) > len_cur)
                begin
                    day_next = len_cur;
                end
                else
                begin
                    day_next = day_reg - 5'd1;
                end
            end
            REQ_MONTH_UP:
            begin
                month_next = month_up;
                day_next   = day_clamped;
            end
            REQ_MONTH_DOWN:
            begin
                month_next = month_down;
                day_next   = day_clamped;
            end
            REQ_YEAR_UP:
            begin
                year_next = year_up;
                day_next  = day_clamped;
            end
            REQ_YEAR_DOWN:
            begin
                year_next = year_down;
                day_next  = day_clamped;
            end
            REQ_HOUR_UP:
            begin
                hour_next = (hour_inc >= 6'd24) ? (hour_inc[HOUR_W-1:0] - 5'd24)
                                                : hour_inc[HOUR_W-1:0];
            end
            REQ_HOUR_DOWN:
            begin
                if (hour_dec >= 6'd48)
                begin
                    hour_next = 5'(hour_dec - 6'd48);
                end
                else if (hour_dec >= 6'd24)
                begin
                    hour_next = 5'(hour_dec - 6'd24);
                end
                else
                begin
                    hour_next = hour_dec[HOUR_W-1:0];
                end
            end
            REQ_MIN_UP:
            begin
                minute_next = (min_inc >= 7'd60) ? 6'(min_inc - 7'd60)
                                                 : min_inc[MINUTE_W-1:0];
                second_next = '0;
            end
            REQ_MIN_DOWN:
            begin
                if (min_dec >= 7'd120)
                begin
                    minute_next = 6'(min_dec - 7'd120);
                end
                else if (min_dec >= 7'd60)
                begin
                    minute_next = 6'(min_dec - 7'd60);
                end
                else
                begin
                    minute_next = min_dec[MINUTE_W-1:0];
                end
                second_next = '0;
            end
            default:
            begin
                year_next = year_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            year_out_reg   <= year_next;
            month_out_reg  <= month_next;
            day_out_reg    <= day_next;
            hour_out_reg   <= hour_next;
            minute_out_reg <= minute_next;
            second_out_reg <= second_next;
        end
    end

    assign done       = done_reg;
    assign new_year   = year_out_reg;
    assign new_month  = month_out_reg;
    assign new_day    = day_out_reg;
    assign new_hour   = hour_out_reg;
    assign new_minute = minute_out_reg;
    assign new_second = second_out_reg;

    // checks
    `CFE_ASSERT_NOW(a_done_follows_start, done, $past(start, 2),
        "result strobe without an item two cycles before")
    `CFE_ASSERT_NEXT(a_valid_to_done, in_valid_reg, done,
        "captured item did not produce a result")
    `CFE_ASSERT_NOW(a_month_range, done && $past(in_valid_reg, 1),
        (new_month >= 4'd1 || $past(req_reg, 1) != REQ_MONTH_UP) &&
        (new_month <= 4'd12 || $past(req_reg, 1) != REQ_MONTH_DOWN),
        "month edit left range")
    `CFE_ASSERT_NOW(a_min_clears_sec,
        done && ($past(req_type, 2) == REQ_MIN_UP || $past(req_type, 2) == REQ_MIN_DOWN),
        new_second == '0, "minute edit kept seconds")
    `CFE_ASSERT_NOW(a_year_saturates,
        done && ($past(req_type, 2) == REQ_YEAR_UP || $past(req_type, 2) == REQ_YEAR_DOWN),
        new_year >= YEAR_MIN && new_year <= YEAR_MAX, "year edit left range")

endmodule

`default_nettype wire
